@@ rtl/free_list_insert_coalesce_macros.svh @@
// Assertion macros for the free-list coalescing block.
`ifndef FREE_LIST_INSERT_COALESCE_MACROS_SVH
`define FREE_LIST_INSERT_COALESCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define FLIC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FLIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FLIC_ASSERT_IMPL(lbl, ante, cons, msg)
`define FLIC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/flic_pkg.sv @@
// Shared types and constants for the free-list coalescing block.
`timescale 1ns / 1ps
package flic_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_BITS   = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int STATUS_W    = 3;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERT     = 3'd0,
        STAT_MERGE_NEXT = 3'd1,
        STAT_MERGE_PREV = 3'd2,
        STAT_MERGE_BOTH = 3'd3,
        STAT_FULL       = 3'd4,
        STAT_OVERLAP    = 3'd5
    } status_t;

    // Table operation applied to the cell row
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_MERGE_NEXT,
        OP_MERGE_PREV,
        OP_MERGE_BOTH
    } op_t;

    // One held free block
    typedef struct packed {
        addr_t start;
        addr_t size;
    } entry_t;

    // Freed block broadcast to every cell
    typedef struct packed {
        addr_t s;
        addr_t z;
        addr_t lim;   // s + z
    } bcast_t;

    // Control from the sequencer to every cell
    typedef struct packed {
        logic eval;
        logic apply;
        op_t  op;
    } cell_ctrl_t;

    // Registered position/compare flags of one cell
    typedef struct packed {
        logic prev;   // last block below the freed start
        logic next;   // first valid block at or above the freed start
        logic ovl;    // overlap against the freed block
        logic tp;     // previous block ends at the freed start
        logic tn;     // freed block ends at this block's start
    } cell_flag_t;

endpackage

@@ rtl/flic_cell.sv @@
// One table cell: holds a free block, locates it against the freed block, shifts and merges.
`timescale 1ns / 1ps
module flic_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                valid_i,      // entry holds a block
    input  flic_pkg::bcast_t    bcast_i,
    input  flic_pkg::cell_ctrl_t ctrl_i,
    input  flic_pkg::entry_t    left_i,       // neighbor below
    input  flic_pkg::entry_t    right_i,      // neighbor above
    input  logic                lt_left_i,    // neighbor below starts under the freed start
    input  logic                lt_right_i,   // neighbor above starts under the freed start
    output logic                lt_o,
    output flic_pkg::entry_t    entry_o,
    output flic_pkg::cell_flag_t flag_o,
    output flic_pkg::entry_t    res_o         // updated entry when this cell holds the result
);
    import flic_pkg::*;

    entry_t     entry_reg, entry_next;
    cell_flag_t flag_reg, flag_next;
    logic       lt_reg, lt_next;
    logic       at_reg, at_next;
    logic       sel;
    logic [ADDR_BITS:0] pend;

    // Block sits below the freed start
    assign lt_o    = valid_i && (entry_reg.start < bcast_i.s);
    assign entry_o = entry_reg;
    assign flag_o  = flag_reg;
    assign pend    = {1'b0, entry_reg.start} + {1'b0, entry_reg.size};

    // Locate and compare against the freed block
    always_comb begin
        flag_next = flag_reg;
        lt_next   = lt_reg;
        at_next   = at_reg;
        if (ctrl_i.eval) begin
            lt_next        = lt_o;
            at_next        = !lt_o && lt_left_i;
            flag_next.prev = lt_o && !lt_right_i;
            flag_next.next = valid_i && !lt_o && lt_left_i;
            flag_next.ovl  = (flag_next.prev && (pend > {1'b0, bcast_i.s})) ||
                             (flag_next.next && (bcast_i.lim > entry_reg.start));
            flag_next.tp   = flag_next.prev && (pend == {1'b0, bcast_i.s});
            flag_next.tn   = flag_next.next && (bcast_i.lim == entry_reg.start);
        end
    end

    // Shift, insert or merge
    always_comb begin
        entry_next = entry_reg;
        sel        = 1'b0;
        case (ctrl_i.op)
            OP_INSERT: begin
                if (at_reg) begin
                    entry_next.start = bcast_i.s;
                    entry_next.size  = bcast_i.z;
                end else if (!lt_reg) begin
                    entry_next = left_i;
                end
            end
            OP_MERGE_NEXT: begin
                if (flag_reg.next) begin
                    entry_next.start = bcast_i.s;
                    entry_next.size  = entry_reg.size + bcast_i.z;
                    sel              = 1'b1;
                end
            end
            OP_MERGE_PREV: begin
                if (flag_reg.prev) begin
                    entry_next.size = entry_reg.size + bcast_i.z;
                    sel             = 1'b1;
                end
            end
            OP_MERGE_BOTH: begin
                if (flag_reg.prev) begin
                    entry_next.size = entry_reg.size + bcast_i.z + right_i.size;
                    sel             = 1'b1;
                end else if (!lt_reg) begin
                    entry_next = right_i;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    assign res_o = sel ? entry_next : '0;

    // Payload holds no reset
    always_ff @(posedge aclk) begin
        if (ctrl_i.apply) begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= '0;
            lt_reg   <= 1'b0;
            at_reg   <= 1'b0;
        end else begin
            flag_reg <= flag_next;
            lt_reg   <= lt_next;
            at_reg   <= at_next;
        end
    end

endmodule

@@ rtl/free_list_insert_coalesce.sv @@
// An item passes the EVAL, DECIDE and APPLY states, then its result is registered
// onto m_tvalid. Each item is accepted, located in the cell row, decided and applied;
// s_tready is low until it is applied; APPLY waits while an untaken result is held.
// The sequencer drives the steps: each cell compares, then the row shifts or merges in one step.
// Reset: aresetn low empties the table (count 0) and clears the handshake state;
// no clearing pass, the block takes items from the first cycle after reset.
`timescale 1ns / 1ps
`include "free_list_insert_coalesce_macros.svh"
module free_list_insert_coalesce (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] freed_start, [63:32] freed_size
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata     // [2:0] status, [34:3] result_start,
                                    // [66:35] result_size, [71:67] entry_count
);
    import flic_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_APPLY  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    cnt_t       count_reg, count_next;
    bcast_t     bcast_reg;
    logic       bad_reg;
    op_t        op_reg, op_next;
    status_t    status_reg, status_next;
    logic       m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic       s_xfer, m_xfer, advance;
    logic [ADDR_BITS:0] in_sum;
    cell_ctrl_t ctrl;

    logic   [TABLE_DEPTH-1:0] valid_vec, lt_vec, prev_vec;
    entry_t [TABLE_DEPTH-1:0] entry_vec, res_vec;
    cell_flag_t [TABLE_DEPTH-1:0] flag_vec;
    logic   any_ovl, any_tp, any_tn;
    entry_t res_or, res_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid_reg && m_tready;
    assign advance  = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign in_sum   = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[63:32]};

    assign ctrl.eval  = (state_reg == ST_EVAL);
    assign ctrl.apply = advance;
    assign ctrl.op    = advance ? op_reg : OP_NONE;

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic   lt_left, lt_right;
        entry_t left_e, right_e;
        assign valid_vec[i] = (CNT_W'(i) < count_reg);
        assign prev_vec[i]  = flag_vec[i].prev;
        if (i == 0) begin : g_lo
            assign lt_left = 1'b1;
            assign left_e  = entry_vec[i];
        end else begin : g_lo
            assign lt_left = lt_vec[i-1];
            assign left_e  = entry_vec[i-1];
        end
        if (i == TABLE_DEPTH - 1) begin : g_hi
            assign lt_right = 1'b0;
            assign right_e  = entry_vec[i];
        end else begin : g_hi
            assign lt_right = lt_vec[i+1];
            assign right_e  = entry_vec[i+1];
        end
        flic_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .valid_i    (valid_vec[i]),
            .bcast_i    (bcast_reg),
            .ctrl_i     (ctrl),
            .left_i     (left_e),
            .right_i    (right_e),
            .lt_left_i  (lt_left),
            .lt_right_i (lt_right),
            .lt_o       (lt_vec[i]),
            .entry_o    (entry_vec[i]),
            .flag_o     (flag_vec[i]),
            .res_o      (res_vec[i])
        );
    end

    // Gather the cell flags and the merged entry
    always_comb begin
        any_ovl = 1'b0;
        any_tp  = 1'b0;
        any_tn  = 1'b0;
        res_or  = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            any_ovl = any_ovl | flag_vec[k].ovl;
            any_tp  = any_tp  | flag_vec[k].tp;
            any_tn  = any_tn  | flag_vec[k].tn;
            res_or  = res_or  | res_vec[k];
        end
    end

    // Pick the operation from the flags
    always_comb begin
        op_next     = op_reg;
        status_next = status_reg;
        if (state_reg == ST_DECIDE) begin
            if (bad_reg || any_ovl) begin
                op_next = OP_NONE;      status_next = STAT_OVERLAP;
            end else if (any_tp && any_tn) begin
                op_next = OP_MERGE_BOTH; status_next = STAT_MERGE_BOTH;
            end else if (any_tn) begin
                op_next = OP_MERGE_NEXT; status_next = STAT_MERGE_NEXT;
            end else if (any_tp) begin
                op_next = OP_MERGE_PREV; status_next = STAT_MERGE_PREV;
            end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                op_next = OP_NONE;      status_next = STAT_FULL;
            end else begin
                op_next = OP_INSERT;    status_next = STAT_INSERT;
            end
        end
    end

    // Entry count and reported block
    always_comb begin
        count_next = count_reg;
        res_entry  = '0;
        case (op_reg)
            OP_INSERT: begin
                count_next      = count_reg + 1'b1;
                res_entry.start = bcast_reg.s;
                res_entry.size  = bcast_reg.z;
            end
            OP_MERGE_BOTH: begin
                count_next = count_reg - 1'b1;
                res_entry  = res_or;
            end
            OP_MERGE_NEXT, OP_MERGE_PREV: begin
                res_entry = res_or;
            end
            default: begin
                res_entry = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_xfer) state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_APPLY;
            ST_APPLY:  if (advance) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Input capture and result register payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            bcast_reg.s   <= s_tdata[31:0];
            bcast_reg.z   <= s_tdata[63:32];
            bcast_reg.lim <= in_sum[ADDR_BITS-1:0];
        end
        if (advance) begin
            m_tdata_reg <= {count_next, res_entry.size, res_entry.start, status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            bad_reg      <= 1'b0;
            op_reg       <= OP_NONE;
            status_reg   <= STAT_INSERT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
            if (s_xfer) begin
                bad_reg <= (s_tdata[63:32] == '0) || in_sum[ADDR_BITS];
            end
            if (advance) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_xfer) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    `FLIC_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "count above depth")
    `FLIC_ASSERT_IMPL(a_one_prev, state_reg == ST_DECIDE, $onehot0(prev_vec), "several prev cells")
    `FLIC_ASSERT_NEXT(a_insert_grows, advance && op_reg == OP_INSERT, count_reg == $past(count_reg) + 1'b1, "insert count")
    `FLIC_ASSERT_NEXT(a_full_only, state_reg == ST_DECIDE && status_next == STAT_FULL, count_reg == CNT_W'(TABLE_DEPTH), "full flagged early")

endmodule
